// ===== rtl/cmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex magnitude detect package
// Sample and result beat types, pipeline sizing and the root step function.
// ----------------------------------------------------------------------------
package cmd_pkg;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned MagW          = 16;
  localparam int unsigned SumW          = 2 * SampleW;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned SqrtStages    = (SampleW + StepsPerStage - 1) / StepsPerStage;
  // abs, square, sum, root stages, output register
  localparam int unsigned Latency       = 4 + SqrtStages;
  localparam logic [MagW-1:0] MagMax    = {MagW{1'b1}};

  typedef struct packed {
    logic signed [SampleW-1:0] in_phase;
    logic signed [SampleW-1:0] quadrature;
    logic                      last_sample;
  } cmd_in_t;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic            last_out;
  } cmd_out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } cmd_ctl_t;

  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [SumW-1:0] root;
  } cmd_root_t;

  // One digit of the bitwise square root; bit_v is the current trial bit.
  function automatic cmd_root_t sqrt_step(cmd_root_t cur, logic [SumW-1:0] bit_v);
    cmd_root_t     nxt;
    logic [SumW:0] trial;
    trial = {1'b0, cur.root} + {1'b0, bit_v};
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem  = cur.rem - trial[SumW-1:0];
      nxt.root = (cur.root >> 1) + bit_v;
    end else begin
      nxt.rem  = cur.rem;
      nxt.root = cur.root >> 1;
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/cmd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor root of an unsigned sum, two result bits per register stage.
// ----------------------------------------------------------------------------
module cmd_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_pkg::cmd_ctl_t            ctl_i,
  input  logic [cmd_pkg::SumW-1:0]     value_i,
  output cmd_pkg::cmd_ctl_t            ctl_o,
  output logic [cmd_pkg::SampleW-1:0]  root_o
);

  cmd_pkg::cmd_ctl_t  ctl_q [cmd_pkg::SqrtStages];
  cmd_pkg::cmd_root_t acc_q [cmd_pkg::SqrtStages];

  for (genvar s = 0; s < cmd_pkg::SqrtStages; s++) begin : g_stage
    cmd_pkg::cmd_ctl_t  ctl_src;
    cmd_pkg::cmd_root_t acc_src;
    cmd_pkg::cmd_root_t acc_d;

    if (s == 0) begin : g_head
      assign ctl_src = ctl_i;
      assign acc_src = '{rem: value_i, root: '0};
    end else begin : g_body
      assign ctl_src = ctl_q[s-1];
      assign acc_src = acc_q[s-1];
    end

    always_comb begin
      logic [cmd_pkg::SumW-1:0] bit_v;
      bit_v = '0;
      acc_d = acc_src;
      for (int j = 0; j < cmd_pkg::StepsPerStage; j++) begin
        if (s * cmd_pkg::StepsPerStage + j < cmd_pkg::SampleW) begin
          bit_v = cmd_pkg::SumW'(1) <<
                  (cmd_pkg::SumW - 2 - 2 * (s * cmd_pkg::StepsPerStage + j));
          acc_d = cmd_pkg::sqrt_step(acc_d, bit_v);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_src;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[s] <= acc_d;
    end
  end

  assign ctl_o  = ctl_q[cmd_pkg::SqrtStages-1];
  assign root_o = acc_q[cmd_pkg::SqrtStages-1].root[cmd_pkg::SampleW-1:0];

endmodule

// ===== rtl/complex_magnitude_detect_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex magnitude detect unit
// Floor sqrt(I*I + Q*Q) per complex sample, saturated to 16 bits.
// ----------------------------------------------------------------------------
//  channel  | ports                     | beat taken when
//  ---------+---------------------------+--------------------------
//  sample   | start, busy, sample_i     | start && !busy
//  result   | result_valid_o, result_o  | result_valid_o (one cycle)
//
// One sample per cycle; busy never rises. Each result passes through the abs,
// square and sum registers, eight two-bit root stages and the output register.
// Reset clears the valid and last chain only; no result can be held off, so
// nothing in the pipe ever waits.
module complex_magnitude_detect_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_pkg::cmd_in_t sample_i,
  output logic             result_valid_o,
  output cmd_pkg::cmd_out_t result_o
);

  localparam int unsigned W = cmd_pkg::SampleW;

  cmd_pkg::cmd_ctl_t ctl_abs_q, ctl_sq_q, ctl_sum_q, ctl_root;
  logic [W-1:0]                abs_i_q, abs_q_q;
  logic [cmd_pkg::SumW-1:0]    sq_i_q, sq_q_q, sum_q;
  logic [W-1:0]                root;
  logic                        valid_q;
  cmd_pkg::cmd_out_t           res_d, res_q;
  logic [cmd_pkg::SumW:0]      sum_full;

  assign busy = 1'b0;
  assign sum_full = {1'b0, sq_i_q} + {1'b0, sq_q_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_abs_q <= '0;
      ctl_sq_q  <= '0;
      ctl_sum_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      ctl_abs_q <= '{valid: start && !busy, last: sample_i.last_sample};
      ctl_sq_q  <= ctl_abs_q;
      ctl_sum_q <= ctl_sq_q;
      valid_q   <= ctl_root.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_i_q <= sample_i.in_phase[W-1]   ? (~sample_i.in_phase + W'(1))
                                        : sample_i.in_phase;
    abs_q_q <= sample_i.quadrature[W-1] ? (~sample_i.quadrature + W'(1))
                                        : sample_i.quadrature;
    sq_i_q  <= cmd_pkg::SumW'(abs_i_q) * cmd_pkg::SumW'(abs_i_q);
    sq_q_q  <= cmd_pkg::SumW'(abs_q_q) * cmd_pkg::SumW'(abs_q_q);
    sum_q   <= sum_full[cmd_pkg::SumW-1:0];
    res_q   <= res_d;
  end

  cmd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sum_q),
    .value_i (sum_q),
    .ctl_o   (ctl_root),
    .root_o  (root)
  );

  always_comb begin
    res_d.last_out = ctl_root.last;
    if (cmd_pkg::SumW'(root) > cmd_pkg::SumW'(cmd_pkg::MagMax)) begin
      res_d.magnitude = cmd_pkg::MagMax;
    end else begin
      res_d.magnitude = root[cmd_pkg::MagW-1:0];
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/cmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex magnitude detect checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
module cmd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input cmd_pkg::cmd_in_t  sample_i,
  input logic              result_valid_o,
  input cmd_pkg::cmd_out_t result_o
);

  localparam int unsigned Lat = cmd_pkg::Latency;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat result_valid_o)
    else $error("result beat missing");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Lat))
    else $error("result beat without sample");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat
      (result_o.last_out == $past(sample_i.last_sample, Lat)))
    else $error("last flag mismatch");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && sample_i.in_phase == '0 && sample_i.quadrature == '0)
      |-> ##Lat (result_o.magnitude == '0))
    else $error("zero sample gave nonzero magnitude");

endmodule

bind complex_magnitude_detect_unit cmd_checker u_cmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .sample_i       (sample_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== test/complex_magnitude_detect_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex magnitude detect unit testbench
// Drives complex samples through the start/busy port and predicts each
// magnitude as the floor square root of I*I + Q*Q, saturated to 16 bits,
// with the frame-end flag carried along. Results are checked in order.
// ----------------------------------------------------------------------------

class mag_scoreboard;
  cmd_pkg::cmd_out_t expected_q[$];
  int unsigned       mismatches = 0;

  static function logic [16:0] abs_part(logic signed [15:0] x);
    logic [16:0] ext;
    ext = {x[15], x};
    return x[15] ? (~ext + 17'd1) : ext;
  endfunction

  static function logic [15:0] predict_magnitude(logic signed [15:0] i_part,
                                                 logic signed [15:0] q_part);
    logic [63:0] ai;
    logic [63:0] aq;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    ai    = 64'(abs_part(i_part));
    aq    = 64'(abs_part(q_part));
    rem   = ai * ai + aq * aq;
    root  = '0;
    probe = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function void note_sample(cmd_pkg::cmd_in_t s);
    cmd_pkg::cmd_out_t e;
    e.magnitude = predict_magnitude(s.in_phase, s.quadrature);
    e.last_out  = s.last_sample;
    expected_q.push_back(e);
  endfunction

  function void check_result(cmd_pkg::cmd_out_t got);
    cmd_pkg::cmd_out_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected beat: magnitude %0d last %0b",
                       got.magnitude, got.last_out));
      return;
    end
    e = expected_q.pop_front();
    if (got.magnitude !== e.magnitude || got.last_out !== e.last_out) begin
      report($sformatf("magnitude exp %0d got %0d, last exp %0b got %0b",
                       e.magnitude, got.magnitude, e.last_out, got.last_out));
    end
  endfunction
endclass

module complex_magnitude_detect_unit_tb;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  cmd_pkg::cmd_in_t  sample_i;
  logic              result_valid_o;
  cmd_pkg::cmd_out_t result_o;

  mag_scoreboard sb = new();

  complex_magnitude_detect_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_sample(sample_i);
      if (result_valid_o) sb.check_result(result_o);
    end
  end

  task automatic send_sample(cmd_pkg::cmd_in_t s, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_parts(int i_part, int q_part, bit last);
    cmd_pkg::cmd_in_t s;
    s.in_phase    = 16'(i_part);
    s.quadrature  = 16'(q_part);
    s.last_sample = last;
    send_sample(s, 0);
  endtask

  function automatic logic [15:0] pick_part();
    int edge_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom);
      5, 6:          return 16'(int'($urandom_range(127)) - 64);
      7:             return 16'(edge_vals[$urandom_range(6)]);
      default:       return 16'(int'($urandom_range(65535, 60000)));
    endcase
  endfunction

  function automatic cmd_pkg::cmd_in_t random_sample();
    cmd_pkg::cmd_in_t s;
    s.in_phase    = pick_part();
    s.quadrature  = pick_part();
    s.last_sample = ($urandom_range(7) == 0);
    return s;
  endfunction

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned idle_pct;
    start    = 1'b0;
    sample_i = '0;
    rst_ni   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: zero, unit, signs, full scale, exact and near-exact roots
    send_parts(0, 0, 0);
    send_parts(0, 0, 1);
    send_parts(1, 0, 0);
    send_parts(0, 1, 0);
    send_parts(-1, 0, 0);
    send_parts(0, -1, 1);
    send_parts(-1, -1, 0);
    send_parts(3, 4, 0);
    send_parts(-3, -4, 1);
    send_parts(32767, 0, 0);
    send_parts(0, 32767, 0);
    send_parts(-32768, 0, 0);
    send_parts(0, -32768, 1);
    send_parts(32767, 32767, 0);
    send_parts(-32768, -32768, 1);
    send_parts(-32768, 32767, 0);
    send_parts(32767, -32768, 0);
    send_parts(181, 181, 0);
    send_parts(255, -256, 0);
    send_parts(-1, 32767, 1);
    send_parts(46, -46, 0);
    send_parts(-32767, -32767, 0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 13 : (phase == 1) ? 81 : 0;
      for (int n = 0; n < 450; n++) send_sample(random_sample(), idle_pct);
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (cmd_pkg::Latency + 4) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== complex_magnitude_detect_unit.f =====
rtl/cmd_pkg.sv
rtl/cmd_sqrt.sv
rtl/complex_magnitude_detect_unit.sv
rtl/cmd_checker.sv
test/complex_magnitude_detect_unit_tb.sv
